// ----- hdl/cmykds_pkg.sv -----
`default_nettype none

package cmykds_pkg;

   // Fixed geometry of one item and of the lane array
   localparam int MAX_PLANES  = 8;
   localparam int NUM_LANES   = 8;
   localparam int LANE_IDX_W  = 3;
   localparam int CSR_W       = 24;
   localparam int LINE_REG_W  = 14;

   // Register indexes on the csr port
   localparam logic [2:0] REG_PLANE_COUNT  = 3'd0;
   localparam logic [2:0] REG_COLOR_MAP    = 3'd1;
   localparam logic [2:0] REG_LEVEL_MODE   = 3'd2;
   localparam logic [2:0] REG_ZOOM_RATIO   = 3'd3;
   localparam logic [2:0] REG_OUT_WIDTH    = 3'd4;
   localparam logic [2:0] REG_OUT_HEIGHT   = 3'd5;
   localparam logic [2:0] REG_LINE_BYTES   = 3'd6;

   // Level sizes; the fourth code behaves as eight-bit levels
   localparam logic [1:0] LVL_1BIT = 2'd0;
   localparam logic [1:0] LVL_2BIT = 2'd1;
   localparam logic [1:0] LVL_8BIT = 2'd2;

   // Colour codes of the slot map
   localparam logic [2:0] COL_C = 3'd0;
   localparam logic [2:0] COL_M = 3'd1;
   localparam logic [2:0] COL_Y = 3'd2;
   localparam logic [2:0] COL_K = 3'd3;

   typedef struct packed {
      logic [7:0] c;
      logic [7:0] m;
      logic [7:0] y;
      logic [7:0] k;
   } ink_bytes_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef pixel_type [NUM_LANES-1:0] pixel_row_type;

   typedef struct packed {
      logic [LANE_IDX_W-1:0] last_idx;
      logic                  eor;
   } group_type;

endpackage

`default_nettype wire

// ----- hdl/cmykds_mod.sv -----
`default_nettype none

module cmykds_mod #(
   parameter int POS_W = 13
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [POS_W-1:0] dividend,
   input  wire logic [7:0]       divisor,
   output logic                  busy,
   output logic                  done,
   output logic [7:0]            remainder
);

   localparam int CNT_W = $clog2(POS_W + 1);

   logic [POS_W-1:0] quo_ff, quo_in;
   logic [7:0]       rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [8:0]       trial;

   // one restoring step a cycle, dividend bits MSB first
   always_comb begin
      trial = {rem_ff, quo_ff[POS_W-1]};
      if (trial >= {1'b0, divisor}) begin
         rem_in = 8'(trial - {1'b0, divisor});
      end else begin
         rem_in = trial[7:0];
      end
      quo_in = quo_ff << 1;
   end

   assign busy      = (cnt_ff != '0);
   assign done      = done_ff;
   assign remainder = rem_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(POS_W);
      end else if (busy) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/cmykds_lane.sv -----
`default_nettype none

module cmykds_lane
   import cmykds_pkg::*;
#(
   parameter int LANE = 0
) (
   input  wire logic          clock,
   input  wire logic          load,
   input  wire ink_bytes_type ink,
   input  wire logic [1:0]    mode_in,
   input  wire logic [1:0]    mode_held,
   output pixel_type          pix
);

   localparam logic [7:0] TOP_1BIT = 8'h1;
   localparam logic [7:0] TOP_2BIT = 8'h3;
   localparam logic [7:0] TOP_8BIT = 8'd255;

   // floor(p * 255 / 9) for the two-bit level products 0 to 9
   localparam logic [7:0] SCALE_2BIT [16] = '{
      8'd0, 8'd28, 8'd56, 8'd85, 8'd113, 8'd141, 8'd170, 8'd198,
      8'd226, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };

   localparam int SHIFT_1BIT = 7 - (LANE % 8);
   localparam int SHIFT_2BIT = 2 * (3 - (LANE % 4));

   logic [15:0] prod_c_ff, prod_m_ff, prod_y_ff;
   logic [15:0] prod_c_in, prod_m_in, prod_y_in;
   logic [7:0]  top;
   logic [7:0]  lv_c, lv_m, lv_y, lv_k;
   logic [7:0]  inv_k;

   function automatic logic [7:0] unpack(logic [7:0] b, logic [1:0] mode);
      unique case (mode)
         LVL_1BIT: return (b >> SHIFT_1BIT) & 8'h1;
         LVL_2BIT: return (b >> SHIFT_2BIT) & 8'h3;
         default:  return b;
      endcase
   endfunction

   // exact floor(p / 255) for p <= 255 * 255; two-bit by lookup, one-bit by a zero test
   function automatic logic [7:0] scale(logic [15:0] p, logic [1:0] mode);
      logic [16:0] q;
      q = 17'(p) + 17'd1 + 17'(p >> 8);
      unique case (mode)
         LVL_1BIT: return (p != '0) ? 8'hFF : 8'h00;
         LVL_2BIT: return SCALE_2BIT[p[3:0]];
         default:  return q[15:8];
      endcase
   endfunction

   always_comb begin
      unique case (mode_in)
         LVL_1BIT: top = TOP_1BIT;
         LVL_2BIT: top = TOP_2BIT;
         default:  top = TOP_8BIT;
      endcase
      lv_c  = unpack(ink.c, mode_in);
      lv_m  = unpack(ink.m, mode_in);
      lv_y  = unpack(ink.y, mode_in);
      lv_k  = unpack(ink.k, mode_in);
      inv_k = top - lv_k;
      prod_c_in = (top - lv_c) * inv_k;
      prod_m_in = (top - lv_m) * inv_k;
      prod_y_in = (top - lv_y) * inv_k;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_c_ff <= prod_c_in;
         prod_m_ff <= prod_m_in;
         prod_y_ff <= prod_y_in;
      end
   end

   assign pix.red   = scale(prod_c_ff, mode_held);
   assign pix.green = scale(prod_m_ff, mode_held);
   assign pix.blue  = scale(prod_y_ff, mode_held);

endmodule

`default_nettype wire

// ----- hdl/cmykds_merge.sv -----
`default_nettype none

module cmykds_merge
   import cmykds_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire group_type     grp_in,
   input  wire pixel_row_type pix_in,
   output logic               ready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [23:0]        rsp_tdata,
   output logic               rsp_tlast,
   output logic               rsp_tuser
);

   pixel_row_type         pix_ff;
   group_type             grp_ff;
   logic                  valid_ff, valid_in;
   logic [LANE_IDX_W-1:0] idx_ff, idx_in;
   logic                  take, finish;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = pix_ff[idx_ff];
   assign rsp_tlast  = (idx_ff == grp_ff.last_idx);
   assign rsp_tuser  = rsp_tlast && grp_ff.eor;

   assign take   = valid_ff && rsp_tready;
   assign finish = take && rsp_tlast;
   assign ready  = !valid_ff || finish;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (finish) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + LANE_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff <= pix_in;
         grp_ff <= grp_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/planar_cmyk_to_rgb_downscaler.sv -----
`default_nettype none

// Channel  Dir  Handshake          Payload
// req      in   tvalid/tready      tdata[63:0]: plane_byte_0 .. plane_byte_7
// rsp      out  tvalid/tready      tdata[23:0]: red, green, blue; tlast: last_in_run;
//                                  tuser: end_of_row
// csr      in   csr_wen            csr_index[2:0], csr_wdata[23:0]
//
// A kept word gives up to 8, 4 or 1 pixels (one-, two-, eight-bit levels); the
// output word register sends one pixel a cycle while rsp_tready is high.
// A word that yields no pixel is accepted without entering the pipeline. The
// first pixel passes the slot select, lane multiply and pixel group registers.
// Reset is synchronous; it clears all counters and loads the register defaults.
// Writing zoom_ratio starts a bit-serial remainder of the line position, which
// holds req_tready low until the remainder is loaded into the column phase.
// A stalled rsp fills the group, lane and slot stages, then drops req_tready.

module planar_cmyk_to_rgb_downscaler
   import cmykds_pkg::*;
#(
   parameter int MAX_LINE_BYTES = 8192
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // plane_byte_0 .. plane_byte_7, eight bits each from the lowest bit up
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [63:0]       req_tdata,
   // red, green, blue from the lowest bit up
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [23:0]            rsp_tdata,
   output logic                   rsp_tlast,
   // end_of_row
   output logic                   rsp_tuser,
   input  wire logic              csr_wen,
   input  wire logic [2:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   localparam int POS_W = $clog2(MAX_LINE_BYTES);
   localparam int LEN_W = (POS_W + 1 > LINE_REG_W) ? POS_W + 1 : LINE_REG_W;
   localparam logic [LEN_W-1:0] LINE_MAX = LEN_W'(MAX_LINE_BYTES);

   // configuration
   logic [3:0]            plane_count_ff;
   logic [23:0]           color_map_ff;
   logic [1:0]            level_mode_ff;
   logic [7:0]            zoom_ratio_ff;
   logic [15:0]           out_width_ff;
   logic [15:0]           out_height_ff;
   logic [LINE_REG_W-1:0] line_bytes_ff;

   // raster position
   logic [POS_W-1:0] byte_pos_ff, byte_pos_in;
   logic [7:0]       col_phase_ff, col_phase_in;
   logic [7:0]       row_phase_ff, row_phase_in;
   logic [15:0]      row_count_ff, row_count_in;
   logic [15:0]      pixel_count_ff, pixel_count_in;

   // pipeline
   logic          s1_valid_ff, s1_valid_in;
   ink_bytes_type s1_ink_ff;
   logic [1:0]    s1_mode_ff;
   group_type     s1_grp_ff;
   logic          s2_valid_ff, s2_valid_in;
   logic [1:0]    s2_mode_ff;
   group_type     s2_grp_ff;
   pixel_row_type lane_pix;

   logic [7:0]       zoom_eff;
   logic [LEN_W-1:0] line_eff, pos_inc;
   logic             line_end;
   logic [8:0]       col_inc, row_inc;
   logic             active, kept, step;
   ink_bytes_type    ink_sel;
   logic [3:0]       per_byte, grp_n;
   logic [16:0]      px_left;
   logic             width_done, grp_hit;
   group_type        grp_new;
   logic             mod_busy, mod_done, mod_start;
   logic [7:0]       mod_rem;
   logic             merge_ready, s2_free, s1_move, s1_load, merge_load;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= 4'd4;
         color_map_ff   <= 24'd1672;
         level_mode_ff  <= LVL_2BIT;
         zoom_ratio_ff  <= 8'd1;
         out_width_ff   <= 16'd1024;
         out_height_ff  <= 16'd1024;
         line_bytes_ff  <= LINE_REG_W'(256);
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_PLANE_COUNT: plane_count_ff <= csr_wdata[3:0];
            REG_COLOR_MAP:   color_map_ff   <= csr_wdata[23:0];
            REG_LEVEL_MODE:  level_mode_ff  <= csr_wdata[1:0];
            REG_ZOOM_RATIO:  zoom_ratio_ff  <= csr_wdata[7:0];
            REG_OUT_WIDTH:   out_width_ff   <= csr_wdata[15:0];
            REG_OUT_HEIGHT:  out_height_ff  <= csr_wdata[15:0];
            REG_LINE_BYTES:  line_bytes_ff  <= csr_wdata[LINE_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Rebuild byte_pos mod zoom after the ratio changes mid-line
   assign mod_start = csr_wen && (csr_index == REG_ZOOM_RATIO);

   cmykds_mod #(
      .POS_W(POS_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (byte_pos_ff),
      .divisor   (zoom_eff),
      .busy      (mod_busy),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // ---------------------------------------------------------------- decode
   always_comb begin
      zoom_eff = (zoom_ratio_ff == '0) ? 8'd1 : zoom_ratio_ff;
      if (line_bytes_ff == '0) begin
         line_eff = LEN_W'(1);
      end else if (LEN_W'(line_bytes_ff) > LINE_MAX) begin
         line_eff = LINE_MAX;
      end else begin
         line_eff = LEN_W'(line_bytes_ff);
      end
      pos_inc  = LEN_W'(byte_pos_ff) + LEN_W'(1);
      line_end = (pos_inc >= line_eff);
      col_inc  = {1'b0, col_phase_ff} + 9'd1;
      row_inc  = {1'b0, row_phase_ff} + 9'd1;
   end

   // Select one byte per colour; a later slot overrides an earlier one.
   // plane_count above eight needs no clamp: every slot index is below it.
   always_comb begin
      ink_sel = '0;
      for (int s = 0; s < MAX_PLANES; s++) begin
         if (4'(s) < plane_count_ff) begin
            unique case (color_map_ff[3*s +: 3])
               COL_C:   ink_sel.c = req_tdata[8*s +: 8];
               COL_M:   ink_sel.m = req_tdata[8*s +: 8];
               COL_Y:   ink_sel.y = req_tdata[8*s +: 8];
               COL_K:   ink_sel.k = req_tdata[8*s +: 8];
               default: ;
            endcase
         end
      end
   end

   // Pixel count of this word: clip at output_width, flag the row end
   always_comb begin
      unique case (level_mode_ff)
         LVL_1BIT: per_byte = 4'd8;
         LVL_2BIT: per_byte = 4'd4;
         default:  per_byte = 4'd1;
      endcase
      active     = (row_count_ff < out_height_ff);
      kept       = (row_phase_ff == '0) && (col_phase_ff == '0);
      width_done = (pixel_count_ff >= out_width_ff);
      px_left    = {1'b0, out_width_ff} - {1'b0, pixel_count_ff};
      if (!kept || width_done) begin
         grp_n = 4'd0;
      end else if (px_left < 17'(per_byte)) begin
         grp_n = px_left[3:0];
      end else begin
         grp_n = per_byte;
      end
      grp_hit          = (grp_n != '0);
      grp_new.last_idx = LANE_IDX_W'(grp_n - 4'd1);
      grp_new.eor      = !width_done && (px_left <= 17'(per_byte));
   end

   // ---------------------------------------------------------------- flow
   assign s2_free    = !s2_valid_ff || merge_ready;
   assign s1_move    = s1_valid_ff && s2_free;
   assign req_tready = !mod_busy && !mod_done && (!s1_valid_ff || s2_free);
   assign step       = req_tvalid && req_tready && active;
   assign s1_load    = step && grp_hit;
   assign merge_load = s2_valid_ff && merge_ready;

   assign s1_valid_in = s1_load || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move || (s2_valid_ff && !merge_load);

   // Step the raster position or load the mod remainder; past the height limit drop words untouched
   always_comb begin
      byte_pos_in    = byte_pos_ff;
      col_phase_in   = col_phase_ff;
      row_phase_in   = row_phase_ff;
      row_count_in   = row_count_ff;
      pixel_count_in = pixel_count_ff;
      if (mod_done) begin
         col_phase_in = mod_rem;
      end else if (step) begin
         if (line_end) begin
            byte_pos_in    = '0;
            col_phase_in   = '0;
            pixel_count_in = '0;
            if ((row_phase_ff == '0) && (row_count_ff != '1)) begin
               row_count_in = row_count_ff + 16'd1;
            end
            row_phase_in = (row_inc >= {1'b0, zoom_eff}) ? '0 : row_inc[7:0];
         end else begin
            byte_pos_in    = byte_pos_ff + POS_W'(1);
            col_phase_in   = (col_inc >= {1'b0, zoom_eff}) ? '0 : col_inc[7:0];
            pixel_count_in = pixel_count_ff + 16'(grp_n);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff    <= '0;
         col_phase_ff   <= '0;
         row_phase_ff   <= '0;
         row_count_ff   <= '0;
         pixel_count_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         byte_pos_ff    <= byte_pos_in;
         col_phase_ff   <= col_phase_in;
         row_phase_ff   <= row_phase_in;
         row_count_ff   <= row_count_in;
         pixel_count_ff <= pixel_count_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
      end
   end

   // Hold the selected inks and group info alongside the lane stages
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ink_ff  <= ink_sel;
         s1_mode_ff <= level_mode_ff;
         s1_grp_ff  <= grp_new;
      end
      if (s1_move) begin
         s2_mode_ff <= s1_mode_ff;
         s2_grp_ff  <= s1_grp_ff;
      end
   end

   // ---------------------------------------------------------------- lanes
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      cmykds_lane #(
         .LANE(l)
      ) u_lane (
         .clock     (clock),
         .load      (s1_move),
         .ink       (s1_ink_ff),
         .mode_in   (s1_mode_ff),
         .mode_held (s2_mode_ff),
         .pix       (lane_pix[l])
      );
   end

   // Collect the lane pixels and send them out in order
   cmykds_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (merge_load),
      .grp_in     (s2_grp_ff),
      .pix_in     (lane_pix),
      .ready      (merge_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // ---------------------------------------------------------------- checks
   a_col_phase_range: assert property (@(posedge clock) disable iff (reset)
      (!mod_busy && !mod_done) |-> (col_phase_ff < zoom_eff))
      else $error("column phase not below zoom ratio");

   a_row_end_count: assert property (@(posedge clock) disable iff (reset)
      (s1_load && grp_new.eor && !line_end && !csr_wen)
         |=> (pixel_count_ff == out_width_ff))
      else $error("pixel count off at end of row");

   a_row_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(step && line_end) |=> $stable(row_count_ff))
      else $error("row counter moved outside a line end");

endmodule

`default_nettype wire

// ----- bench/planar_cmyk_to_rgb_downscaler_test.sv -----
`timescale 1ns / 100ps

module planar_cmyk_to_rgb_downscaler_test;
   import cmykds_pkg::*;

   localparam int LINE_BYTES_MAX = 8192;
   localparam int RANDOM_WORDS   = 230;
   // Allow for the pipeline and for a word that yields nothing before touching the
   // registers or ending the run.
   localparam int SETTLE_CYCLES  = 24;
   localparam int CYCLE_LIMIT    = 200000;

   // One expected pixel and its two flags
   typedef struct {
      pixel_type px;
      bit        run_end;
      bit        row_end;
   } pixel_expect_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;     // plane_byte_0 .. plane_byte_7, 8 bits each
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;     // red, green, blue
   logic        rsp_tlast;     // last_in_run
   logic        rsp_tuser;     // end_of_row
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [CSR_W-1:0] csr_wdata;

   planar_cmyk_to_rgb_downscaler #(
      .MAX_LINE_BYTES(LINE_BYTES_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Register copies, held at the widths of the block
   logic [3:0]  cfg_planes;
   logic [23:0] cfg_map;
   logic [1:0]  cfg_level;
   logic [7:0]  cfg_zoom;
   logic [15:0] cfg_width;
   logic [15:0] cfg_height;
   logic [13:0] cfg_line;

   // Raster position state of the converter
   logic [12:0] st_pos;
   logic [15:0] st_rows;
   logic [7:0]  st_phase;
   logic [15:0] st_pixels;

   pixel_expect_type pending_pixels[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  sent_words  = 0;
   int  burst_left  = 0;
   bit  gaps_on     = 1'b1;
   bit  block_idle  = 1'b1;
   int  ready_tick  = 0;
   int  ready_mode  = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Guard against a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixels outstanding", $time, pending_pixels.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: switch between always ready, random stalls and a fixed stall
   // pattern so stalls land on every phase of a pixel run.
   always @(negedge clock) begin
      ready_tick++;
      if (ready_tick % 128 == 0)
         ready_mode = $urandom_range(0, 3);
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ((ready_tick % 11) > 3);
         default: rsp_tready <= $urandom_range(0, 1);
      endcase
   end

   function automatic logic [7:0] ink_to_rgb(input int unsigned lvl, input int unsigned k,
                                             input int unsigned top);
      return 8'(((top - lvl) * (top - k) * 255) / (top * top));
   endfunction

   function automatic void load_power_on_state();
      cfg_planes = 4'd4;
      cfg_map    = 24'd1672;
      cfg_level  = LVL_2BIT;
      cfg_zoom   = 8'd1;
      cfg_width  = 16'd1024;
      cfg_height = 16'd1024;
      cfg_line   = 14'd256;
      st_pos     = '0;
      st_rows    = '0;
      st_phase   = '0;
      st_pixels  = '0;
   endfunction

   // Work out the pixels of one accepted word and advance the raster position.
   // Words that arrive once all rows are done leave no trace.
   task automatic convert_word(input logic [63:0] bytes);
      int unsigned zoom, line_len, planes, bits, mask, top, per_byte, shift, code, n;
      int unsigned lv[4];
      pixel_expect_type run[8];
      zoom = (cfg_zoom == 0) ? 1 : cfg_zoom;
      if (cfg_line == 0)
         line_len = 1;
      else if (cfg_line > LINE_BYTES_MAX)
         line_len = LINE_BYTES_MAX;
      else
         line_len = cfg_line;
      planes = (cfg_planes > MAX_PLANES) ? MAX_PLANES : cfg_planes;
      if (st_rows >= cfg_height)
         return;
      case (cfg_level)
         LVL_1BIT: begin bits = 1; mask = 'h1;  top = 1;   per_byte = 8; end
         LVL_2BIT: begin bits = 2; mask = 'h3;  top = 3;   per_byte = 4; end
         default:  begin bits = 8; mask = 'hFF; top = 255; per_byte = 1; end
      endcase
      n = 0;
      if (st_phase == 0 && (st_pos % zoom) == 0) begin
         for (int p = 0; p < per_byte; p++) begin
            if (st_pixels >= cfg_width)
               break;
            shift = (per_byte - 1 - p) * bits;
            lv = '{0, 0, 0, 0};
            // later slots override earlier ones with the same colour
            for (int s = 0; s < planes; s++) begin
               code = (cfg_map >> (3 * s)) & 'h7;
               if (code < 4)
                  lv[code] = (bytes[8*s +: 8] >> shift) & mask;
            end
            run[n].px.red   = ink_to_rgb(lv[COL_C], lv[COL_K], top);
            run[n].px.green = ink_to_rgb(lv[COL_M], lv[COL_K], top);
            run[n].px.blue  = ink_to_rgb(lv[COL_Y], lv[COL_K], top);
            run[n].run_end  = 1'b0;
            st_pixels++;
            run[n].row_end  = (st_pixels == cfg_width);
            n++;
         end
         for (int i = 0; i < n; i++) begin
            run[i].run_end = (i == n - 1);
            pending_pixels.push_back(run[i]);
         end
      end
      // close the line, also when the position ran past a shortened line
      if (int'(st_pos) + 1 >= line_len) begin
         st_pos    = '0;
         st_pixels = '0;
         if (st_phase == 0 && st_rows != 16'hFFFF)
            st_rows++;
         if (int'(st_phase) + 1 >= zoom)
            st_phase = '0;
         else
            st_phase++;
      end else begin
         st_pos++;
      end
   endtask

   // Drop valid and hold until every pixel is back and the pipeline is empty
   task automatic wait_idle();
      if (req_tvalid) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      block_idle = 1'b1;
   endtask

   // Write one register; only ever done with the block idle
   task automatic set_reg(input logic [2:0] index, input logic [23:0] value);
      if (!block_idle)
         wait_idle();
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      case (index)
         REG_PLANE_COUNT: cfg_planes = value[3:0];
         REG_COLOR_MAP:   cfg_map    = value[23:0];
         REG_LEVEL_MODE:  cfg_level  = value[1:0];
         REG_ZOOM_RATIO:  cfg_zoom   = value[7:0];
         REG_OUT_WIDTH:   cfg_width  = value[15:0];
         REG_OUT_HEIGHT:  cfg_height = value[15:0];
         REG_LINE_BYTES:  cfg_line   = value[13:0];
         default: ;
      endcase
   endtask

   // Send one word; bursts of random length with random gaps when gaps_on
   task automatic send_word(input logic [63:0] bytes);
      block_idle = 1'b0;
      if (gaps_on && burst_left == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= bytes;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0)
         burst_left--;
      convert_word(bytes);
      sent_words++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] seen);
      if (seen !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
      end
   endtask

   // Check every pixel taken from the block against the oldest expectation
   always @(posedge clock) begin : pixel_check
      pixel_expect_type want;
      pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_pixels.size() == 0) begin
            error_count++;
            $display("%0t: pixel with none expected, expected nothing actual %h %b %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = pending_pixels.pop_front();
            compare_field("red", want.px.red, got.red);
            compare_field("green", want.px.green, got.green);
            compare_field("blue", want.px.blue, got.blue);
            compare_field("last_in_run", 8'(want.run_end), 8'(rsp_tlast));
            compare_field("end_of_row", 8'(want.row_end), 8'(rsp_tuser));
         end
      end
   end

   // White, black, every two-bit level, a lone black ink and a random word on reset settings
   task automatic test_default_config();
      send_word(64'h0);
      send_word({8{8'hFF}});
      send_word({8{8'hE4}});
      send_word(64'h0000_0000_FF00_0000);
      send_word({$urandom, $urandom});
   endtask

   // One word per level size, the fourth code acting as eight bits
   task automatic test_level_modes();
      for (int m = 0; m < 4; m++) begin
         set_reg(REG_LEVEL_MODE, m);
         send_word({$urandom, $urandom});
      end
   endtask

   // Overrides by later slots, ignored codes, missing and clamped plane counts
   task automatic test_color_map();
      set_reg(REG_LEVEL_MODE, LVL_8BIT);
      set_reg(REG_PLANE_COUNT, MAX_PLANES);
      set_reg(REG_COLOR_MAP, {COL_C, COL_M, COL_Y, COL_K, COL_K, COL_Y, COL_M, COL_C});
      send_word(64'h1122_3344_5566_7788);
      set_reg(REG_COLOR_MAP, 24'hFFFFFF);
      send_word({$urandom, $urandom});
      set_reg(REG_COLOR_MAP, 24'h0);
      send_word({$urandom, $urandom});
      set_reg(REG_COLOR_MAP, 24'd1672);
      set_reg(REG_PLANE_COUNT, 0);
      send_word({8{8'h80}});
      set_reg(REG_PLANE_COUNT, 15);
      send_word({$urandom, $urandom});
      set_reg(REG_PLANE_COUNT, 1);
      send_word({8{8'hC0}});
   endtask

   // Zoom, line length, row width and row count limits
   task automatic test_geometry();
      set_reg(REG_PLANE_COUNT, 4);
      set_reg(REG_LEVEL_MODE, LVL_1BIT);
      // shortening the line ends the current one at once
      set_reg(REG_LINE_BYTES, 2);
      set_reg(REG_ZOOM_RATIO, 0);
      send_word({$urandom, $urandom});
      set_reg(REG_ZOOM_RATIO, 2);
      repeat (6) send_word({$urandom, $urandom});
      // width reached mid-word, then a short line with no end of row
      set_reg(REG_ZOOM_RATIO, 1);
      set_reg(REG_OUT_WIDTH, 5);
      repeat (2) send_word({$urandom, $urandom});
      set_reg(REG_OUT_WIDTH, 20);
      repeat (2) send_word({$urandom, $urandom});
      set_reg(REG_OUT_WIDTH, 0);
      send_word({$urandom, $urandom});
      // all rows done: words are dropped without effect
      set_reg(REG_OUT_WIDTH, 16'hFFFF);
      set_reg(REG_OUT_HEIGHT, st_rows);
      repeat (2) send_word({$urandom, $urandom});
      set_reg(REG_OUT_HEIGHT, 16'hFFFF);
   endtask

   // Random settings per phase, random data, mostly short lines and small zoom
   task automatic test_random_traffic();
      logic [23:0] map;
      int n;
      sent_words = 0;
      while (sent_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0: set_reg(REG_PLANE_COUNT, 0);
            1: set_reg(REG_PLANE_COUNT, 15);
            2: set_reg(REG_PLANE_COUNT, 1);
            3: set_reg(REG_PLANE_COUNT, MAX_PLANES);
            default: set_reg(REG_PLANE_COUNT, $urandom_range(1, MAX_PLANES));
         endcase
         map = '0;
         for (int s = 0; s < MAX_PLANES; s++)
            map[3*s +: 3] = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7)
                                                        : $urandom_range(0, 3);
         case ($urandom_range(0, 11))
            0: map = 24'h0;
            1: map = 24'hFFFFFF;
            default: ;
         endcase
         set_reg(REG_COLOR_MAP, map);
         set_reg(REG_LEVEL_MODE, $urandom_range(0, 3));
         case ($urandom_range(0, 11))
            0: set_reg(REG_ZOOM_RATIO, 0);
            1: set_reg(REG_ZOOM_RATIO, 255);
            2, 3, 4: set_reg(REG_ZOOM_RATIO, $urandom_range(2, 4));
            default: set_reg(REG_ZOOM_RATIO, 1);
         endcase
         case ($urandom_range(0, 9))
            0: set_reg(REG_OUT_WIDTH, 0);
            1: set_reg(REG_OUT_WIDTH, 1);
            2: set_reg(REG_OUT_WIDTH, 16'hFFFF);
            default: set_reg(REG_OUT_WIDTH, $urandom_range(2, 100));
         endcase
         case ($urandom_range(0, 11))
            0: set_reg(REG_OUT_HEIGHT, 0);
            1: set_reg(REG_OUT_HEIGHT, 1);
            2: set_reg(REG_OUT_HEIGHT, st_rows + $urandom_range(1, 3));
            default: set_reg(REG_OUT_HEIGHT, 16'hFFFF);
         endcase
         case ($urandom_range(0, 11))
            0: set_reg(REG_LINE_BYTES, LINE_BYTES_MAX);
            1: set_reg(REG_LINE_BYTES, 14'h3FFF);
            2: set_reg(REG_LINE_BYTES, 0);
            default: set_reg(REG_LINE_BYTES, $urandom_range(1, 12));
         endcase
         gaps_on = ($urandom_range(0, 2) != 0);
         n = $urandom_range(8, 24);
         for (int i = 0; i < n; i++) begin
            // now and then hold the sender until the block has drained
            if (i == n / 2 && $urandom_range(0, 3) == 0)
               wait_idle();
            case ($urandom_range(0, 15))
               0: send_word(64'h0);
               1: send_word({8{8'hFF}});
               default: send_word({$urandom, $urandom});
            endcase
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      load_power_on_state();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_default_config();
      test_level_modes();
      test_color_map();
      test_geometry();
      test_random_traffic();

      wait_idle();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
